[rtl/md5de_pkg.sv]
// md5de_pkg: shared types, constants and round tables for the MD5 digest engine.
// Used by md5de_front, md5de_queue, md5de_back and md5_digest_engine.
package md5de_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } item_t;

  typedef struct packed {
    logic pop;
    logic digest_load;
  } bk_status_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] g;
    lo = i[3:0];
    case (i[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'(lo * 4'd5 + 4'd1);
      2'd2:    g = 4'(lo * 4'd3 + 4'd5);
      default: g = 4'(lo * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] phase,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] f;
    case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage

[rtl/md5de_front.sv]
// md5de_front: input stage; registers each word and classifies its byte count.
// Depends on md5de_pkg; feeds md5de_queue.
module md5de_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,   // [31:0] data_word, [34:32] valid_bytes, rest zero
  input  logic                s_tlast,
  output logic                push,
  output md5de_pkg::item_t    push_item,
  input  logic                q_full
);

  logic             held;
  md5de_pkg::item_t item;
  md5de_pkg::item_t item_next;

  assign s_tready  = !held || !q_full;
  assign push      = held && !q_full;
  assign push_item = item;

  always_comb begin
    item_next.word = s_tdata[31:0];
    item_next.last = s_tlast;
    if (!s_tlast || s_tdata[34:32] > md5de_pkg::FULL_WORD_BYTES) begin
      item_next.nbytes = md5de_pkg::FULL_WORD_BYTES;
    end else begin
      item_next.nbytes = s_tdata[34:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_next;
    end
  end

endmodule

[rtl/md5de_queue.sv]
// md5de_queue: short FIFO between the input stage and the compression back end.
// Depends on md5de_pkg for the entry type.
module md5de_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  md5de_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output md5de_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  md5de_pkg::item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/md5de_back.sv]
// md5de_back: block buffer, padding sequencer, one-round-per-cycle MD5 compression
// and digest output register. Depends on md5de_pkg.
module md5de_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  md5de_pkg::item_t       q_item,
  output md5de_pkg::bk_status_t  status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [127:0]           out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_ADD  = 2'd3;

  logic [1:0]  state;
  logic [3:0]  slot;
  logic [3:0]  fptr;
  logic [63:0] bit_count;
  logic        pad_pending;
  logic        len_lo;
  logic        finishing;
  logic        last_block;
  logic [5:0]  round;
  logic [31:0] chain [4];
  logic [31:0] a, b, c, d;
  logic [31:0] blk [16];

  logic        pop;
  logic        digest_ok;
  logic        digest_load;
  logic        load_work;
  logic        buf_we;
  logic [3:0]  buf_addr;
  logic [31:0] buf_wdata;
  logic [31:0] padded_word;
  logic [31:0] fill_word;
  logic [31:0] f_val;
  logic [31:0] sum;
  logic [63:0] rot_wide;
  logic [31:0] new_b;
  logic [31:0] s0, s1, s2, s3;

  assign pop         = (state == ST_IDLE) && q_valid;
  assign digest_ok   = !out_valid || out_ready;
  assign digest_load = (state == ST_ADD) && last_block && digest_ok;
  assign status      = '{pop: pop, digest_load: digest_load};

  always_comb begin
    case (q_item.nbytes)
      3'd0:    padded_word = {24'h0, md5de_pkg::PAD_BYTE};
      3'd1:    padded_word = {16'h0, md5de_pkg::PAD_BYTE, q_item.word[7:0]};
      3'd2:    padded_word = {8'h0, md5de_pkg::PAD_BYTE, q_item.word[15:0]};
      3'd3:    padded_word = {md5de_pkg::PAD_BYTE, q_item.word[23:0]};
      default: padded_word = q_item.word;
    endcase
  end

  always_comb begin
    if (pad_pending) begin
      fill_word = {24'h0, md5de_pkg::PAD_BYTE};
    end else if (fptr == 4'd14) begin
      fill_word = bit_count[31:0];
    end else if (fptr == 4'd15 && len_lo) begin
      fill_word = bit_count[63:32];
    end else begin
      fill_word = '0;
    end
  end

  always_comb begin
    buf_we    = 1'b0;
    buf_addr  = slot;
    buf_wdata = q_item.word;
    if (pop) begin
      buf_we    = 1'b1;
      buf_wdata = q_item.last ? padded_word : q_item.word;
    end else if (state == ST_FILL) begin
      buf_we    = 1'b1;
      buf_addr  = fptr;
      buf_wdata = fill_word;
    end
  end

  // Enter compression with the working words loaded from the chaining value.
  assign load_work = (pop && slot == 4'd15) || (state == ST_FILL && fptr == 4'd15);

  assign f_val    = md5de_pkg::round_f(round[5:4], b, c, d);
  assign sum      = a + f_val + md5de_pkg::round_k(round) + blk[md5de_pkg::msg_index(round)];
  assign rot_wide = {sum, sum} << md5de_pkg::rot_amt(round);
  assign new_b    = b + rot_wide[63:32];

  assign s0 = chain[0] + a;
  assign s1 = chain[1] + b;
  assign s2 = chain[2] + c;
  assign s3 = chain[3] + d;

  always_ff @(posedge clk) begin
    if (buf_we) begin
      blk[buf_addr] <= buf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (load_work) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (state == ST_COMP) begin
      a <= d;
      b <= new_b;
      c <= b;
      d <= c;
    end
    if (digest_load) begin
      out_data <= {s3, s2, s1, s0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      slot        <= '0;
      fptr        <= '0;
      bit_count   <= '0;
      pad_pending <= 1'b0;
      len_lo      <= 1'b0;
      finishing   <= 1'b0;
      last_block  <= 1'b0;
      round       <= '0;
      chain[0]    <= md5de_pkg::IV_A;
      chain[1]    <= md5de_pkg::IV_B;
      chain[2]    <= md5de_pkg::IV_C;
      chain[3]    <= md5de_pkg::IV_D;
      out_valid   <= 1'b0;
    end else begin
      if (digest_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            bit_count <= bit_count + {58'h0, q_item.nbytes, 3'b000};
            slot      <= slot + 1'b1;
            round     <= '0;
            if (q_item.last) begin
              pad_pending <= (q_item.nbytes == md5de_pkg::FULL_WORD_BYTES);
              if (slot == 4'd15) begin
                fptr      <= '0;
                finishing <= 1'b1;
                state     <= ST_COMP;
              end else begin
                fptr  <= slot + 1'b1;
                state <= ST_FILL;
              end
            end else if (slot == 4'd15) begin
              state <= ST_COMP;
            end
          end
        end
        ST_FILL: begin
          pad_pending <= 1'b0;
          fptr        <= fptr + 1'b1;
          round       <= '0;
          if (fptr == 4'd14 && !pad_pending) begin
            len_lo <= 1'b1;
          end
          if (fptr == 4'd15) begin
            last_block <= len_lo;
            finishing  <= !len_lo;
            state      <= ST_COMP;
          end
        end
        ST_COMP: begin
          round <= round + 1'b1;
          if (round == 6'd63) begin
            state <= ST_ADD;
          end
        end
        default: begin
          if (last_block) begin
            if (digest_ok) begin
              chain[0]   <= md5de_pkg::IV_A;
              chain[1]   <= md5de_pkg::IV_B;
              chain[2]   <= md5de_pkg::IV_C;
              chain[3]   <= md5de_pkg::IV_D;
              slot       <= '0;
              bit_count  <= '0;
              len_lo     <= 1'b0;
              last_block <= 1'b0;
              state      <= ST_IDLE;
            end
          end else begin
            chain[0] <= s0;
            chain[1] <= s1;
            chain[2] <= s2;
            chain[3] <= s3;
            if (finishing) begin
              finishing <= 1'b0;
              fptr      <= '0;
              state     <= ST_FILL;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

[rtl/md5_digest_engine.sv]
// md5_digest_engine: MD5 digest over a stream of little-endian 32-bit words.
// Depends on md5de_pkg, md5de_front, md5de_queue and md5de_back.
//
// Usage:
//   Slave stream s_*: one message word per transaction. s_tdata[31:0] is the word
//   (byte 0 in bits 7:0), s_tdata[34:32] the valid byte count, used only when
//   s_tlast marks the final word (counts above 4 act as 4).
//   Master stream m_*: one 128-bit digest per message, A in bits 31:0 up to D
//   in bits 127:96.
// Timing:
//   A registered input stage and a QUEUE_DEPTH-entry queue take words while the
//   back end compresses. The back end stores one word per cycle while it is idle
//   and runs the 64 MD5 rounds one per cycle, then a chaining-add step, so the
//   rate for full blocks is set by the single round unit. After the final word,
//   padding and length words are written, and one or two compressions follow
//   before m_tvalid rises.
// Reset: rst clears the queue, loads the MD5 initial vector and drops m_tvalid.
// Stall: a held digest stays in the output register; the back end waits before
//   loading the next digest, and the queue then fills and drops s_tready.
module md5_digest_engine #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // [31:0] data_word, [34:32] valid_bytes, rest zero
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // [63:0] digest_low, [127:64] digest_high
);

  logic                  q_push;
  logic                  q_full;
  logic                  q_valid;
  md5de_pkg::item_t      q_in;
  md5de_pkg::item_t      q_out;
  md5de_pkg::bk_status_t bk_status;

  md5de_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .push      (q_push),
    .push_item (q_in),
    .q_full    (q_full)
  );

  md5de_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (bk_status.pop),
    .not_empty (q_valid),
    .pop_item  (q_out)
  );

  md5de_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_out),
    .status    (bk_status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

`ifndef ASSERT_OFF
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue push while full");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    bk_status.pop |-> q_valid) else $error("queue pop while empty");

  a_digest_room: assert property (@(posedge clk) disable iff (rst)
    bk_status.digest_load |-> (!m_tvalid || m_tready))
    else $error("digest overwrites a pending result");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result valid after reset");
`endif

endmodule
